[design/rmf_pkg.sv]
// ----------------------------------------------------------------------------
// rmf_pkg
// Shared types and constants of the Modbus RTU request framer: the payloads of
// the request and response channels and the command passed from front to back.
// ----------------------------------------------------------------------------
package rmf_pkg;

   localparam int BYTE_W      = 8;
   localparam int WORD_W      = 16;
   localparam int COUNT_W     = 7;
   localparam int CMD_BYTES   = 8;
   localparam int NBYTES_W    = $clog2(CMD_BYTES);
   localparam int CSR_INDEX_W = 1;

   // register indexes of the configuration port
   localparam logic [CSR_INDEX_W-1:0] CSR_WRITE_START = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_READ_START  = 1'b1;

   typedef struct packed {
      logic                operation;
      logic [BYTE_W-1:0]   slave_address;
      logic [BYTE_W-1:0]   func_code;
      logic [COUNT_W-1:0]  register_count;
      logic [WORD_W-1:0]   data_word;
   } req_payload_type;

   typedef struct packed {
      logic [BYTE_W-1:0]   tx_byte;
      logic                last_byte;
      logic [BYTE_W-1:0]   reply_length;
   } rsp_payload_type;

   // one unit of work for the byte sequencer: plain bytes, then optional CRC
   typedef struct packed {
      logic [0:CMD_BYTES-1][BYTE_W-1:0] bytes;
      logic [NBYTES_W-1:0]             nbytes;
      logic                            add_crc;
      logic                            new_frame;
      logic [BYTE_W-1:0]               reply_length;
   } cmd_type;

endpackage

[design/modbus_rtu_request_framer.sv]
// ----------------------------------------------------------------------------
// modbus_rtu_request_framer
// Builds Modbus RTU master request frames (read holding, write multiple, other
// codes) one byte per beat, closed by the CRC-16, low byte first.
//
//   port group   dir   handshake           payload
//   req_*        in    req_valid/req_stall req_data  (rmf_pkg::req_payload_type)
//   rsp_*        out   rsp_valid/rsp_stall rsp_data  (rmf_pkg::rsp_payload_type)
//   csr_*        in    csr_we              csr_index, csr_wdata
//
// An item yields 0 to 8 bytes (start items 4, 7 or 8, data words 2 or 4);
// the back-end sequencer sends them one byte a cycle while the output is not stalled.
// The front accepts an item per cycle while the two-entry command queue
// has room; stray data words are taken and dropped at once.
// Reset is synchronous and clears the frame state, queue and output register;
// both start-register addresses reset to zero.
// rsp_stall holds the output beat; the back end and then the queue fill behind
// it before req_stall rises.
// ----------------------------------------------------------------------------
module modbus_rtu_request_framer #(
   parameter int MAX_REGISTERS = 125
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  rmf_pkg::req_payload_type            req_data,
   output logic                                req_stall,
   output logic                                rsp_valid,
   output rmf_pkg::rsp_payload_type            rsp_data,
   input  logic                                rsp_stall,
   input  logic                                csr_we,
   input  logic [rmf_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [rmf_pkg::WORD_W-1:0]          csr_wdata
);
   import rmf_pkg::*;

   logic    push;
   logic    push_ready;
   cmd_type push_cmd;
   logic    q_valid;
   logic    q_pop;
   cmd_type q_cmd;

   rmf_front #(
      .MAX_REGISTERS (MAX_REGISTERS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_data   (req_data),
      .req_stall  (req_stall),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .push       (push),
      .push_cmd   (push_cmd),
      .push_ready (push_ready)
   );

   rmf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .push_ready (push_ready),
      .pop        (q_pop),
      .pop_cmd    (q_cmd),
      .pop_valid  (q_valid)
   );

   rmf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_cmd     (q_cmd),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

endmodule

[design/rmf_front.sv]
// ----------------------------------------------------------------------------
// rmf_front
// Accepts request items, holds the frame state and configuration registers,
// and turns each item into a byte command for the back end.
// ----------------------------------------------------------------------------
module rmf_front #(
   parameter int MAX_REGISTERS = 125
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  rmf_pkg::req_payload_type            req_data,
   output logic                                req_stall,
   input  logic                                csr_we,
   input  logic [rmf_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [rmf_pkg::WORD_W-1:0]          csr_wdata,
   output logic                                push,
   output rmf_pkg::cmd_type                    push_cmd,
   input  logic                                push_ready
);
   import rmf_pkg::*;

   localparam logic                OP_START          = 1'b0;
   localparam logic [BYTE_W-1:0]   FC_READ_HOLDING   = 8'd3;
   localparam logic [BYTE_W-1:0]   FC_WRITE_MULTIPLE = 8'd16;
   localparam logic [BYTE_W-1:0]   WRITE_REPLY_BYTES = 8'd8;
   localparam logic [BYTE_W-1:0]   READ_REPLY_BASE   = 8'd5;
   localparam logic [COUNT_W-1:0]  COUNT_LIMIT       = COUNT_W'(MAX_REGISTERS);

   logic [WORD_W-1:0]  write_start_ff, write_start_in;
   logic [WORD_W-1:0]  read_start_ff, read_start_in;
   logic [COUNT_W-1:0] words_left_ff, words_left_in;
   logic [BYTE_W-1:0]  held_reply_ff, held_reply_in;

   logic               accept;
   logic               is_start;
   logic [COUNT_W-1:0] count_sat;
   logic [COUNT_W-1:0] count_wr;
   logic [BYTE_W-1:0]  start_reply;

   assign req_stall = !push_ready;
   assign accept    = req_valid && push_ready;
   assign is_start  = req_data.operation == OP_START;
   assign count_sat = (req_data.register_count > COUNT_LIMIT) ? COUNT_LIMIT
                                                                : req_data.register_count;
   assign count_wr  = (count_sat == '0) ? COUNT_W'(1) : count_sat;

   always_comb begin
      priority if (req_data.func_code == FC_READ_HOLDING) begin
         start_reply = READ_REPLY_BASE + BYTE_W'({count_sat, 1'b0});
      end else if (req_data.func_code == FC_WRITE_MULTIPLE) begin
         start_reply = WRITE_REPLY_BYTES;
      end else begin
         start_reply = '0;
      end
   end

   // classify the item and build its command
   always_comb begin
      push_cmd = '0;
      push     = accept && (is_start || words_left_ff != '0);
      if (is_start) begin
         push_cmd.bytes[0]     = req_data.slave_address;
         push_cmd.bytes[1]     = req_data.func_code;
         push_cmd.new_frame    = 1'b1;
         push_cmd.reply_length = start_reply;
         priority if (req_data.func_code == FC_READ_HOLDING) begin
            push_cmd.bytes[2] = read_start_ff[WORD_W-1:BYTE_W];
            push_cmd.bytes[3] = read_start_ff[BYTE_W-1:0];
            push_cmd.bytes[4] = '0;
            push_cmd.bytes[5] = BYTE_W'(count_sat);
            push_cmd.nbytes   = NBYTES_W'(6);
            push_cmd.add_crc  = 1'b1;
         end else if (req_data.func_code == FC_WRITE_MULTIPLE) begin
            push_cmd.bytes[2] = write_start_ff[WORD_W-1:BYTE_W];
            push_cmd.bytes[3] = write_start_ff[BYTE_W-1:0];
            push_cmd.bytes[4] = '0;
            push_cmd.bytes[5] = BYTE_W'(count_wr);
            push_cmd.bytes[6] = BYTE_W'({count_wr, 1'b0});
            push_cmd.nbytes   = NBYTES_W'(7);
            push_cmd.add_crc  = 1'b0;
         end else begin
            push_cmd.nbytes   = NBYTES_W'(2);
            push_cmd.add_crc  = 1'b1;
         end
      end else begin
         push_cmd.bytes[0]     = req_data.data_word[WORD_W-1:BYTE_W];
         push_cmd.bytes[1]     = req_data.data_word[BYTE_W-1:0];
         push_cmd.nbytes       = NBYTES_W'(2);
         push_cmd.add_crc      = words_left_ff == COUNT_W'(1);
         push_cmd.new_frame    = 1'b0;
         push_cmd.reply_length = held_reply_ff;
      end
   end

   always_comb begin
      write_start_in = write_start_ff;
      read_start_in  = read_start_ff;
      words_left_in  = words_left_ff;
      held_reply_in  = held_reply_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_WRITE_START: write_start_in = csr_wdata;
            CSR_READ_START:  read_start_in  = csr_wdata;
            default:         ;
         endcase
      end
      if (accept && is_start) begin
         held_reply_in = start_reply;
         words_left_in = (req_data.func_code == FC_WRITE_MULTIPLE) ? count_wr : '0;
      end else if (push) begin
         words_left_in = words_left_ff - COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_start_ff <= '0;
         read_start_ff  <= '0;
         words_left_ff  <= '0;
         held_reply_ff  <= '0;
      end else begin
         write_start_ff <= write_start_in;
         read_start_ff  <= read_start_in;
         words_left_ff  <= words_left_in;
         held_reply_ff  <= held_reply_in;
      end
   end

   a_words_bound: assert property (@(posedge clock) disable iff (reset)
      words_left_ff <= COUNT_LIMIT)
      else $error("words left beyond register limit");

   a_data_continues: assert property (@(posedge clock) disable iff (reset)
      push && !is_start |-> push_cmd.reply_length == WRITE_REPLY_BYTES)
      else $error("data word pushed outside a write frame");

endmodule

[design/rmf_queue.sv]
// ----------------------------------------------------------------------------
// rmf_queue
// Two-entry command queue between front and back end.
// ----------------------------------------------------------------------------
module rmf_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  rmf_pkg::cmd_type   push_cmd,
   output logic               push_ready,
   input  logic               pop,
   output rmf_pkg::cmd_type   pop_cmd,
   output logic               pop_valid
);
   import rmf_pkg::*;

   localparam int DEPTH = 2;

   cmd_type                     slots_ff [DEPTH];
   logic                        wr_ptr_ff, wr_ptr_in;
   logic                        rd_ptr_ff, rd_ptr_in;
   logic [$clog2(DEPTH+1)-1:0]  count_ff, count_in;

   assign push_ready = count_ff != 2'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_cmd    = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'(DEPTH))
      else $error("queue overfilled");

endmodule

[design/rmf_back.sv]
// ----------------------------------------------------------------------------
// rmf_back
// Byte sequencer: walks each command one byte a cycle unless stalled, keeps
// the running CRC-16 and closes frames with the CRC, low byte first.
// ----------------------------------------------------------------------------
module rmf_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       q_valid,
   input  rmf_pkg::cmd_type           q_cmd,
   output logic                       q_pop,
   output logic                       rsp_valid,
   output rmf_pkg::rsp_payload_type   rsp_data,
   input  logic                       rsp_stall
);
   import rmf_pkg::*;

   localparam logic [WORD_W-1:0] CRC_INIT = 16'hFFFF;
   localparam logic [WORD_W-1:0] CRC_POLY = 16'hA001;

   function automatic logic [WORD_W-1:0] crc_byte(input logic [WORD_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
      logic [WORD_W-1:0] c;
      c = crc ^ WORD_W'(b);
      for (int i = 0; i < BYTE_W; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   cmd_type           cur_ff, cur_in;
   logic              busy_ff, busy_in;
   logic [NBYTES_W-1:0] idx_ff, idx_in;
   logic [WORD_W-1:0] crc_ff, crc_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type   rsp_ff, rsp_in;

   logic              out_free;
   logic              advance;
   logic              in_data;
   logic              at_crc_lo;
   logic              at_end;
   logic [NBYTES_W-1:0] final_pos;
   logic [WORD_W-1:0] crc_base;
   logic [BYTE_W-1:0] data_byte;
   logic [BYTE_W-1:0] byte_out;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = busy_ff && out_free;
   assign in_data   = idx_ff < cur_ff.nbytes;
   assign at_crc_lo = idx_ff == cur_ff.nbytes;
   assign final_pos = cur_ff.add_crc ? NBYTES_W'(cur_ff.nbytes + NBYTES_W'(1))
                                     : NBYTES_W'(cur_ff.nbytes - NBYTES_W'(1));
   assign at_end    = idx_ff == final_pos;
   assign crc_base  = (cur_ff.new_frame && idx_ff == '0) ? CRC_INIT : crc_ff;
   assign data_byte = cur_ff.bytes[idx_ff];
   assign q_pop     = q_valid && (!busy_ff || (advance && at_end));

   always_comb begin
      priority if (in_data) begin
         byte_out = data_byte;
      end else if (at_crc_lo) begin
         byte_out = crc_ff[BYTE_W-1:0];
      end else begin
         byte_out = crc_ff[WORD_W-1:BYTE_W];
      end
   end

   always_comb begin
      cur_in       = cur_ff;
      busy_in      = busy_ff;
      idx_in       = idx_ff;
      crc_in       = crc_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (q_pop) begin
         cur_in  = q_cmd;
         busy_in = 1'b1;
         idx_in  = '0;
      end else if (advance && at_end) begin
         busy_in = 1'b0;
      end else if (advance) begin
         idx_in = idx_ff + NBYTES_W'(1);
      end
      if (advance && in_data) begin
         crc_in = crc_byte(crc_base, data_byte);
      end
      if (advance) begin
         rsp_valid_in        = 1'b1;
         rsp_in.tx_byte      = byte_out;
         rsp_in.last_byte    = cur_ff.add_crc && at_end;
         rsp_in.reply_length = cur_ff.reply_length;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= '0;
         crc_ff       <= CRC_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         crc_ff       <= crc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> idx_ff <= final_pos)
      else $error("byte index past end of command");

   a_cmd_min: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cur_ff.nbytes >= NBYTES_W'(2))
      else $error("command shorter than two bytes");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      advance && cur_ff.add_crc && at_end |=> rsp_valid_ff && rsp_ff.last_byte)
      else $error("closing CRC byte not flagged as last");

endmodule

[verif/rmf_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmf_checker
// Watches the request, response and register ports of the request framer,
// rebuilds every frame byte by byte with its own CRC-16 and compares each
// response beat in order against the bytes it expects.
// ----------------------------------------------------------------------------
module rmf_checker #(
   parameter int         MAX_REGISTERS     = 125,
   parameter logic       OP_START          = 1'b0,
   parameter logic [7:0] FC_READ_HOLDING   = 8'd3,
   parameter logic [7:0] FC_WRITE_MULTIPLE = 8'd16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  rmf_pkg::req_payload_type        req_data,
   input  logic                            req_stall,
   input  logic                            rsp_valid,
   input  rmf_pkg::rsp_payload_type        rsp_data,
   input  logic                            rsp_stall,
   input  logic                            csr_we,
   input  logic [rmf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rmf_pkg::WORD_W-1:0]      csr_wdata,
   output int                              fail_count,
   output int                              pending
);
   import rmf_pkg::*;

   localparam logic [7:0]  WRITE_REPLY_BYTES = 8'd8;
   localparam logic [15:0] CRC_SEED          = 16'hFFFF;
   localparam logic [15:0] CRC_POLY          = 16'hA001;
   localparam int          MAX_REPORTS       = 100;

   logic [WORD_W-1:0]  write_start;
   logic [WORD_W-1:0]  read_start;
   logic [15:0]        frame_crc;
   logic [COUNT_W-1:0] words_owed;
   logic               frame_open;
   logic [BYTE_W-1:0]  reply_len;

   rsp_payload_type    wire_bytes[$];
   int                 errors  = 0;
   int                 reports = 0;

   function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
      crc = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         if (crc[0]) crc = (crc >> 1) ^ CRC_POLY;
         else crc = crc >> 1;
      end
      return crc;
   endfunction

   task automatic queue_byte(input logic [7:0] b, input logic last);
      rsp_payload_type beat;
      beat.tx_byte      = b;
      beat.last_byte    = last;
      beat.reply_length = reply_len;
      wire_bytes.push_back(beat);
   endtask

   task automatic frame_byte(input logic [7:0] b);
      frame_crc = crc_fold(frame_crc, b);
      queue_byte(b, 1'b0);
   endtask

   // CRC goes out low byte first and closes the frame
   task automatic close_frame();
      queue_byte(frame_crc[7:0], 1'b0);
      queue_byte(frame_crc[15:8], 1'b1);
      frame_crc  = CRC_SEED;
      frame_open = 1'b0;
      words_owed = '0;
   endtask

   task automatic frame_request(input req_payload_type req);
      logic [COUNT_W-1:0] qty;
      qty = (req.register_count > MAX_REGISTERS) ? COUNT_W'(MAX_REGISTERS)
                                                  : req.register_count;
      if (req.operation == OP_START) begin
         // a start always drops whatever frame was still open
         frame_crc  = CRC_SEED;
         frame_open = 1'b1;
         words_owed = '0;
         if (req.func_code == FC_READ_HOLDING) reply_len = 8'(5 + 2 * qty);
         else if (req.func_code == FC_WRITE_MULTIPLE) reply_len = WRITE_REPLY_BYTES;
         else reply_len = '0;
         frame_byte(req.slave_address);
         frame_byte(req.func_code);
         if (req.func_code == FC_READ_HOLDING) begin
            frame_byte(read_start[15:8]);
            frame_byte(read_start[7:0]);
            frame_byte(8'h00);
            frame_byte({1'b0, qty});
            close_frame();
         end else if (req.func_code == FC_WRITE_MULTIPLE) begin
            if (qty == 0) qty = 1;
            frame_byte(write_start[15:8]);
            frame_byte(write_start[7:0]);
            frame_byte(8'h00);
            frame_byte({1'b0, qty});
            frame_byte({qty, 1'b0});
            words_owed = qty;
         end else begin
            close_frame();
         end
      end else if (frame_open && words_owed != 0) begin
         // frame data words that an open write is waiting for; any other word is dropped
         frame_byte(req.data_word[15:8]);
         frame_byte(req.data_word[7:0]);
         words_owed = words_owed - 1'b1;
         if (words_owed == 0) close_frame();
      end
   endtask

   task automatic check_beat(input rsp_payload_type got);
      rsp_payload_type want;
      if (wire_bytes.size() == 0) begin
         errors++;
         if (reports < MAX_REPORTS) begin
            reports++;
            $display("%0t: unexpected beat, expected none, got byte %02h last %0b reply %0d",
                     $time, got.tx_byte, got.last_byte, got.reply_length);
         end
      end else begin
         want = wire_bytes.pop_front();
         if (got.tx_byte !== want.tx_byte || got.last_byte !== want.last_byte ||
             got.reply_length !== want.reply_length) begin
            errors++;
            if (reports < MAX_REPORTS) begin
               reports++;
               $display("%0t: beat mismatch, expected byte %02h last %0b reply %0d, %s %02h %0b %0d",
                        $time, want.tx_byte, want.last_byte, want.reply_length,
                        "got", got.tx_byte, got.last_byte, got.reply_length);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         write_start = '0;
         read_start  = '0;
         frame_crc   = CRC_SEED;
         words_owed  = '0;
         frame_open  = 1'b0;
         reply_len   = '0;
         wire_bytes.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_WRITE_START: write_start = csr_wdata;
               CSR_READ_START:  read_start  = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) check_beat(rsp_data);
         if (req_valid && !req_stall) frame_request(req_data);
      end
      pending    <= wire_bytes.size();
      fail_count <= errors;
   end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the Modbus RTU request framer: directed frames at the field
// limits, then phases of random read, write and other frames under random
// idling on both channels, with one long response hold-off to fill the block.
// ----------------------------------------------------------------------------
module tb_top;
   import rmf_pkg::*;

   localparam int         MAX_REGISTERS     = 125;
   localparam logic       OP_START          = 1'b0;
   localparam logic       OP_DATA           = 1'b1;
   localparam logic [7:0] FC_READ_HOLDING   = 8'd3;
   localparam logic [7:0] FC_WRITE_MULTIPLE = 8'd16;
   localparam int         LIMIT_CYCLES      = 200000;
   localparam int         SETTLE_CYCLES     = 20;
   localparam int         HOLD_OFF_CYCLES   = 400;
   localparam int         PHASE_ITEMS       = 15;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   req_payload_type        req_data  = '0;
   logic                   req_stall;
   logic                   rsp_valid;
   rsp_payload_type        rsp_data;
   logic                   rsp_stall = 1'b0;
   logic                   csr_we    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_WRITE_START;
   logic [WORD_W-1:0]      csr_wdata = '0;

   int   fail_count;
   int   pending;
   int   cycle_count = 0;
   int   items_sent  = 0;
   bit   eager       = 1'b0;
   logic squeeze     = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   modbus_rtu_request_framer #(.MAX_REGISTERS(MAX_REGISTERS)) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   rmf_checker #(
      .MAX_REGISTERS     (MAX_REGISTERS),
      .OP_START          (OP_START),
      .FC_READ_HOLDING   (FC_READ_HOLDING),
      .FC_WRITE_MULTIPLE (FC_WRITE_MULTIPLE)
   ) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_data   (req_data),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .rsp_stall  (rsp_stall),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic req_payload_type start_beat(input logic [7:0] addr,
                                                  input logic [7:0] code,
                                                  input logic [6:0] count);
      req_payload_type item;
      item.operation      = OP_START;
      item.slave_address  = addr;
      item.func_code      = code;
      item.register_count = count;
      item.data_word      = WORD_W'($urandom);
      return item;
   endfunction

   function automatic req_payload_type word_beat(input logic [15:0] word);
      req_payload_type item;
      item.operation      = OP_DATA;
      item.slave_address  = BYTE_W'($urandom);
      item.func_code      = BYTE_W'($urandom);
      item.register_count = COUNT_W'($urandom);
      item.data_word      = word;
      return item;
   endfunction

   // hold the beat until the block takes it
   task automatic send_item(input req_payload_type item);
      int gap;
      gap = eager ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   // wait for every expected byte, then let the back end settle
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_starts(input logic [15:0] wr_start, input logic [15:0] rd_start);
      csr_we    <= 1'b1;
      csr_index <= CSR_WRITE_START;
      csr_wdata <= wr_start;
      @(posedge clock);
      csr_index <= CSR_READ_START;
      csr_wdata <= rd_start;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic random_frame();
      int kind;
      int count;
      int words;
      kind = $urandom_range(0, 9);
      case (kind)
         0, 1, 2: begin
            send_item(start_beat(BYTE_W'($urandom), FC_READ_HOLDING, COUNT_W'($urandom)));
         end
         3, 4, 5, 6: begin
            count = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 127)
                                                 : $urandom_range(0, 4);
            words = (count == 0) ? 1 : ((count > MAX_REGISTERS) ? MAX_REGISTERS : count);
            // cut long frames short, and now and then a short one too
            if (words > 8) words = $urandom_range(0, 4);
            else if ($urandom_range(0, 7) == 0) words = $urandom_range(0, words - 1);
            send_item(start_beat(BYTE_W'($urandom), FC_WRITE_MULTIPLE, COUNT_W'(count)));
            repeat (words) send_item(word_beat(WORD_W'($urandom)));
         end
         7: begin
            send_item(start_beat(BYTE_W'($urandom), BYTE_W'($urandom), COUNT_W'($urandom)));
         end
         default: begin
            send_item(word_beat(WORD_W'($urandom)));
         end
      endcase
   endtask

   // receiver: random back-pressure per beat, idle-free stretches, one long hold-off
   initial begin : rsp_side
      int  wait_cycles;
      int  beats;
      bit  held_off;
      beats    = 0;
      held_off = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (squeeze && !held_off) begin
            held_off    = 1'b1;
            wait_cycles = HOLD_OFF_CYCLES;
         end else if ((beats / 24) % 3 == 2) begin
            wait_cycles = 0;
         end else begin
            wait_cycles = $urandom_range(0, 14);
         end
         if (wait_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         beats++;
      end
   end

   initial begin : req_side
      int          phase_end;
      logic [15:0] wr_start;
      logic [15:0] rd_start;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset values of both start registers in use
      send_item(start_beat(8'h00, FC_READ_HOLDING, 7'd0));
      send_item(start_beat(8'hFF, FC_READ_HOLDING, 7'd125));
      send_item(start_beat(8'h11, FC_READ_HOLDING, 7'd127));
      // zero count write takes a single word
      send_item(start_beat(8'h01, FC_WRITE_MULTIPLE, 7'd0));
      send_item(word_beat(16'hFFFF));
      send_item(start_beat(8'h02, FC_WRITE_MULTIPLE, 7'd2));
      send_item(word_beat(16'h0000));
      send_item(word_beat(16'hA55A));
      send_item(start_beat(8'h03, 8'h00, 7'h7F));
      send_item(start_beat(8'h04, 8'hFF, 7'd0));
      send_item(start_beat(8'h05, 8'd4, 7'd1));
      send_item(word_beat(16'h1234));
      // abandon an open write with a read
      send_item(start_beat(8'h06, FC_WRITE_MULTIPLE, 7'd3));
      send_item(word_beat(16'h00FF));
      send_item(start_beat(8'h07, FC_READ_HOLDING, 7'd1));
      send_item(word_beat(16'hFF00));
      // saturated write count, abandoned by another code
      send_item(start_beat(8'h08, FC_WRITE_MULTIPLE, 7'd126));
      send_item(word_beat(16'h8000));
      send_item(start_beat(8'h09, 8'd6, 7'd5));
      drain();

      write_starts(16'hFFFF, 16'hFFFF);
      send_item(start_beat(8'hAA, FC_READ_HOLDING, 7'd1));
      send_item(start_beat(8'h55, FC_WRITE_MULTIPLE, 7'd1));
      send_item(word_beat(16'h7FFF));

      for (int phase = 0; phase < 4; phase++) begin
         drain();
         case (phase)
            0: begin
               wr_start = 16'h0000;
               rd_start = 16'hFFFF;
            end
            1: begin
               wr_start = 16'hFFFF;
               rd_start = 16'h0000;
            end
            default: begin
               wr_start = WORD_W'($urandom);
               rd_start = WORD_W'($urandom);
            end
         endcase
         write_starts(wr_start, rd_start);
         // pressure phase: offer beats back to back while the receiver holds off
         eager = (phase == 2);
         if (phase == 2) squeeze <= 1'b1;
         if (phase == 3) begin
            send_item(start_beat(BYTE_W'($urandom), FC_WRITE_MULTIPLE, 7'd20));
            repeat (20) send_item(word_beat(WORD_W'($urandom)));
         end
         phase_end = items_sent + PHASE_ITEMS;
         while (items_sent < phase_end) random_frame();
      end

      drain();
      if (fail_count == 0 && pending == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

[sim.f]
design/rmf_pkg.sv
design/rmf_front.sv
design/rmf_queue.sv
design/rmf_back.sv
design/modbus_rtu_request_framer.sv
verif/rmf_checker.sv
verif/tb_top.sv
